/* rtl/core/ssp_pkg.sv */
// package for the sequential servo pulse generator
// holds payload structs, operation and register codes, sizes; no dependencies
package ssp_pkg;

    localparam int CHANNELS = 12;
    localparam int PINS     = 12;
    localparam int SLOT_W   = $clog2(CHANNELS + 1);

    localparam logic [15:0] WIDTH_NONE = 16'hFFFF;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [2:0] REG_MIN_PULSE = 3'd0;
    localparam logic [2:0] REG_MAX_PULSE = 3'd1;
    localparam logic [2:0] REG_CENTER    = 3'd2;
    localparam logic [2:0] REG_PAUSE     = 3'd3;
    localparam logic [2:0] REG_REVERSE   = 3'd4;

    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         channel;
        logic signed [15:0] time_us;
    } in_t;

    typedef struct packed {
        logic [PINS-1:0]    pins;
        logic signed [14:0] read_value;
        logic               in_pause;
    } out_t;

    typedef struct packed {
        logic [13:0]     min_pulse_us;
        logic [13:0]     center_us;
        logic [15:0]     pause_ticks;
        logic [PINS-1:0] reverse_mask;
    } slot_cfg_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        logic [15:0]       ticks;
    } store_wr_t;

    typedef struct packed {
        logic [PINS-1:0] pins;
        logic            in_pause;
    } slot_status_t;

endpackage

/* rtl/core/ssp_slot_ctrl.sv */
// slot sequencer: per-channel width store, tick counter, slot index, pin levels
// depends on ssp_pkg
module ssp_slot_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tick_en,
    input  ssp_pkg::store_wr_t   wr,
    input  ssp_pkg::slot_cfg_t   cfg,
    output ssp_pkg::slot_status_t status_next
);

    logic [15:0]                 store_reg [ssp_pkg::CHANNELS];
    logic [ssp_pkg::SLOT_W-1:0]  slot_reg;
    logic [ssp_pkg::SLOT_W-1:0]  slot_next;
    logic [15:0]                 ticks_reg;
    logic [15:0]                 ticks_next;
    logic [ssp_pkg::PINS-1:0]    pins_reg;
    logic [ssp_pkg::PINS-1:0]    pins_next;

    logic [15:0]                 ticks_dec;
    logic [ssp_pkg::SLOT_W-1:0]  nxt_slot;
    logic [ssp_pkg::SLOT_W-1:0]  nxt_idx;
    logic [15:0]                 nxt_width;
    logic [15:0]                 mirror;
    logic [ssp_pkg::PINS-1:0]    cur_mask;
    logic [ssp_pkg::PINS-1:0]    nxt_mask;
    logic                        cur_is_pause;
    logic                        nxt_is_pause;

    always_comb begin
        ticks_dec    = ticks_reg - 16'd1;
        cur_is_pause = (slot_reg >= ssp_pkg::SLOT_W'(ssp_pkg::CHANNELS));
        nxt_slot     = cur_is_pause ? '0 : slot_reg + ssp_pkg::SLOT_W'(1);
        nxt_is_pause = (nxt_slot >= ssp_pkg::SLOT_W'(ssp_pkg::CHANNELS));
        nxt_idx      = nxt_is_pause ? '0 : nxt_slot;
        nxt_width    = store_reg[nxt_idx];
        mirror       = {cfg.center_us, 2'b00} - nxt_width;
        cur_mask     = (slot_reg < ssp_pkg::SLOT_W'(ssp_pkg::PINS))
                       ? (ssp_pkg::PINS'(1) << slot_reg) : '0;
        nxt_mask     = (nxt_slot < ssp_pkg::SLOT_W'(ssp_pkg::PINS))
                       ? (ssp_pkg::PINS'(1) << nxt_slot) : '0;

        slot_next  = slot_reg;
        ticks_next = ticks_reg;
        pins_next  = pins_reg;
        if (tick_en) begin
            ticks_next = ticks_dec;
            if (ticks_dec == 16'd0) begin
                // end of slot: drop current pin, load the next slot
                slot_next = nxt_slot;
                pins_next = pins_reg & ~cur_mask;
                if (nxt_is_pause) begin
                    ticks_next = cfg.pause_ticks;
                end else if (nxt_width != ssp_pkg::WIDTH_NONE) begin
                    pins_next  = pins_next | nxt_mask;
                    ticks_next = ((cfg.reverse_mask & nxt_mask) != '0) ? mirror : nxt_width;
                end else begin
                    // no pulse: wait the raw min count in ticks
                    ticks_next = {2'b00, cfg.min_pulse_us};
                end
            end
        end
        status_next.pins     = pins_next;
        status_next.in_pause = (slot_next >= ssp_pkg::SLOT_W'(ssp_pkg::CHANNELS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= ssp_pkg::SLOT_W'(ssp_pkg::CHANNELS);
            ticks_reg <= 16'd16000;
            pins_reg  <= '0;
        end else begin
            slot_reg  <= slot_next;
            ticks_reg <= ticks_next;
            pins_reg  <= pins_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ssp_pkg::CHANNELS; i++) begin
                store_reg[i] <= ssp_pkg::WIDTH_NONE;
            end
        end else if (wr.en) begin
            store_reg[wr.idx] <= wr.ticks;
        end
    end

`ifndef SYNTHESIS
    a_pins_onehot0: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(pins_reg))
        else $error("more than one servo pin high");
    a_pause_pins_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_reg >= ssp_pkg::SLOT_W'(ssp_pkg::CHANNELS)) |-> (pins_reg == '0))
        else $error("pin high during pause");
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= ssp_pkg::SLOT_W'(ssp_pkg::CHANNELS))
        else $error("slot index out of range");
    a_pin_is_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (pins_reg & ~cur_mask) == '0)
        else $error("pin high outside its slot");
`endif

endmodule

/* rtl/core/sequential_servo_pulse_generator.sv */
// top level of the sequential servo pulse generator
// config registers, set clamp, read path, result register; uses ssp_pkg, ssp_slot_ctrl
//
//  channel  | direction | payload                           | accepted when
//  s_       | in        | operation, channel, time_us       | s_valid & s_ready
//  m_       | out       | pins, read_value, in_pause        | m_valid & m_ready
//  cfg_     | in        | cfg_index (3b), cfg_data (16b)    | cfg_valid & cfg_ready
//
// one transaction per cycle while s_ready is high: each item updates state at its accept edge and its
// result is captured in the output register at that same edge
// s_ready stays high while the output register is empty or being drained
// cfg_ready is always high; reset is synchronous and clears all state except the output data register
module sequential_servo_pulse_generator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  ssp_pkg::in_t s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output ssp_pkg::out_t m_data,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    logic [13:0]              min_reg;
    logic [13:0]              max_reg;
    logic [13:0]              center_reg;
    logic [15:0]              pause_reg;
    logic [ssp_pkg::PINS-1:0] reverse_reg;

    logic [15:0]              read_store_reg [ssp_pkg::CHANNELS];
    logic                     m_valid_reg;
    ssp_pkg::out_t            m_data_reg;

    logic                       accept;
    logic                       ch_ok;
    logic [ssp_pkg::SLOT_W-1:0] ch_idx;
    logic [7:0]                 ch_dec;
    logic [14:0]                t_max;
    logic [14:0]                t_clamp;
    logic [15:0]                set_ticks;
    logic [15:0]                rd_width;
    logic [14:0]                read_val;
    ssp_pkg::store_wr_t         wr;
    ssp_pkg::slot_cfg_t         slot_cfg;
    ssp_pkg::slot_status_t      status_next;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        ch_dec  = s_data.channel - 8'd1;
        ch_ok   = (s_data.channel >= 8'd1) && (s_data.channel <= 8'(ssp_pkg::CHANNELS));
        ch_idx  = ch_ok ? ch_dec[ssp_pkg::SLOT_W-1:0] : '0;

        // max clamp first, then min clamp wins
        t_max   = (s_data.time_us[14:0] > {1'b0, max_reg}) ? {1'b0, max_reg}
                                                           : s_data.time_us[14:0];
        t_clamp = (t_max < {1'b0, min_reg}) ? {1'b0, min_reg} : t_max;
        set_ticks = s_data.time_us[15] ? ssp_pkg::WIDTH_NONE : {t_clamp, 1'b0};

        wr.en    = accept && (s_data.operation == ssp_pkg::OP_SET) && ch_ok;
        wr.idx   = ch_idx;
        wr.ticks = set_ticks;

        rd_width = read_store_reg[ch_idx];
        read_val = '0;
        if ((s_data.operation == ssp_pkg::OP_READ) && ch_ok) begin
            read_val = (rd_width == ssp_pkg::WIDTH_NONE) ? '1 : rd_width[15:1];
        end

        slot_cfg.min_pulse_us = min_reg;
        slot_cfg.center_us    = center_reg;
        slot_cfg.pause_ticks  = pause_reg;
        slot_cfg.reverse_mask = reverse_reg;
    end

    ssp_slot_ctrl u_slot_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_en     (accept && (s_data.operation == ssp_pkg::OP_TICK)),
        .wr          (wr),
        .cfg         (slot_cfg),
        .status_next (status_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ssp_pkg::CHANNELS; i++) begin
                read_store_reg[i] <= ssp_pkg::WIDTH_NONE;
            end
        end else if (wr.en) begin
            read_store_reg[wr.idx] <= wr.ticks;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg     <= 14'd500;
            max_reg     <= 14'd2500;
            center_reg  <= 14'd1500;
            pause_reg   <= 16'd16000;
            reverse_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ssp_pkg::REG_MIN_PULSE: min_reg     <= cfg_data[13:0];
                ssp_pkg::REG_MAX_PULSE: max_reg     <= cfg_data[13:0];
                ssp_pkg::REG_CENTER:    center_reg  <= cfg_data[13:0];
                ssp_pkg::REG_PAUSE:     pause_reg   <= cfg_data;
                ssp_pkg::REG_REVERSE:   reverse_reg <= cfg_data[ssp_pkg::PINS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg.pins       <= status_next.pins;
            m_data_reg.read_value <= read_val;
            m_data_reg.in_pause   <= status_next.in_pause;
        end
    end

`ifndef SYNTHESIS
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted transaction produced no result");
    a_pause_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.in_pause) |-> (m_data.pins == '0))
        else $error("pins high in pause result");
`endif

endmodule
